>>> src/bmt_pkg.sv
// ----------------------------------------------------------------------------
// bmt_pkg
// Types and constants shared by the blocked multithreaded core.
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam int THREADS    = 4;
    localparam int REGS       = 8;
    localparam int IMEM_WORDS = 256;
    localparam int DMEM_WORDS = 1024;
    localparam int TW = $clog2(THREADS);
    localparam int RW = $clog2(REGS);
    localparam int IW = $clog2(IMEM_WORDS);
    localparam int DW = $clog2(DMEM_WORDS);

    typedef enum logic [1:0] {
        CMD_IWRITE = 2'd0,
        CMD_DWRITE = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_RREAD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_ADDI  = 3'd3,
        OP_SUBI  = 3'd4,
        OP_LOAD  = 3'd5,
        OP_STORE = 3'd6,
        OP_HALT  = 3'd7
    } t_op;

    localparam logic [1:0] CFG_THREADS = 2'd0;
    localparam logic [1:0] CFG_LDLAT   = 2'd1;
    localparam logic [1:0] CFG_STLAT   = 2'd2;
    localparam logic [1:0] CFG_PENALTY = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         thread_sel;
        logic [9:0]         addr;
        logic [2:0]         opcode;
        logic [2:0]         dst_reg;
        logic [2:0]         src_reg;
        logic signed [15:0] src2_or_imm;
        logic               src2_is_imm;
        logic signed [31:0] data_value;
    } t_in;

    typedef struct packed {
        logic [1:0]         ran_thread;
        logic               switched;
        logic               all_done;
        logic [31:0]        cycle_count;
        logic [31:0]        inst_count;
        logic signed [31:0] read_value;
    } t_out;

    typedef struct packed {
        logic       is_imm;
        logic [15:0] imm;
        logic [2:0] s1;
        logic [2:0] d;
        logic [2:0] op;
    } t_inst;

endpackage

>>> src/blocked_multithread_core.sv
// ----------------------------------------------------------------------------
// blocked_multithread_core
// Coarse-grained multithreaded core with internal instruction, data and
// register memories, driven one command at a time.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries one command transaction: write an
// instruction, write a data word, run one core cycle or read a register.
// Every command returns exactly one result transaction on o_valid / i_stall.
// The result passes only the output register after acceptance for a write,
// a register read or a run with every active thread halted, while a run
// passes instruction fetch, source 1 read, source 2 read, data memory
// access, write back and the output register, as the instruction, register
// and data memories are read through registers, each with one read port.
// One command is in flight at a time; the input is stalled until its result
// is taken and the next command can be accepted in the cycle after that.
// When the receiver stalls, the result is held unchanged.
// Synchronous reset clears PCs, wait counters, finished flags, counters and
// current thread, and zeroes the register file by valid bits; the
// instruction and data memories are undefined until written.
// Configuration writes are taken on any cycle through i_cfg_we.
// ----------------------------------------------------------------------------
module blocked_multithread_core import bmt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_OPRD  = 6'b000100,
        S_MEM   = 6'b001000,
        S_WB    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [2:0] r_tcount;
    logic [7:0] r_ldlat, r_stlat, r_pen;

    logic [31:0]     imem [THREADS*IMEM_WORDS];
    logic [31:0]     dmem [DMEM_WORDS];
    logic [31:0]     rf   [THREADS*REGS];
    logic [THREADS*REGS-1:0] r_rf_vld;

    logic [IW-1:0] r_pc    [THREADS];
    logic [7:0]    r_wait  [THREADS];
    logic [THREADS-1:0] r_rdy, r_fin;
    logic [TW-1:0] r_cur;
    logic [31:0]   r_cyc, r_inst;

    t_in           r_cmd;
    t_inst         r_iw;
    logic [31:0]   r_a, r_b;     // register operands
    logic [31:0]   r_imem_q, r_dmem_q, r_rf_q;
    logic          r_rf_qv;
    logic [TW-1:0] r_t;
    logic          r_rd_b;       // operand read phase second read
    t_out          r_out;
    logic          r_ovld;

    // active thread count
    logic [TW:0] n_act;
    always_comb begin
        if (r_tcount == 3'd0) n_act = (TW+1)'(1);
        else if (32'(r_tcount) > THREADS) n_act = (TW+1)'(THREADS);
        else n_act = (TW+1)'(r_tcount);
    end

    logic [THREADS-1:0] act_mask;
    always_comb begin
        for (int i = 0; i < THREADS; i++) act_mask[i] = (i < 32'(n_act));
    end

    function automatic logic [TW-1:0] next_unf(input logic [TW-1:0] c,
                                               input logic [THREADS-1:0] fin,
                                               input logic [TW:0] n);
        logic [TW-1:0] res;
        logic          found;
        logic [TW:0]   k;
        res = c;
        found = 1'b0;
        for (int i = 1; i <= THREADS; i++) begin
            k = (TW+1)'(32'(c) + i);
            if (k >= n) k = k - n;
            if (k >= n) k = k - n;
            if (!found && i <= 32'(n) && !fin[k[TW-1:0]]) begin
                res = k[TW-1:0];
                found = 1'b1;
            end
        end
        return res;
    endfunction

    wire in_acc  = i_valid && !o_stall;
    wire out_acc = r_ovld && !i_stall;
    wire all_h   = ((r_fin | ~act_mask) == '1);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovld;
    assign o_data  = r_out;

    // start-of-run thread resolution
    logic [TW-1:0] c0, t_run;
    always_comb begin
        c0 = (32'(r_cur) >= 32'(n_act)) ? '0 : r_cur;
        t_run = r_fin[c0] ? next_unf(c0, r_fin, n_act) : c0;
    end

    // decoded fetched instruction
    t_inst fw;
    assign fw = t_inst'(r_imem_q[25:0]);
    wire [31:0] immx = {{16{r_iw.imm[15]}}, r_iw.imm};

    // register file read address
    logic [RW+TW-1:0] rf_ra;
    always_comb begin
        if (r_state == S_IDLE) rf_ra = {i_data.thread_sel[TW-1:0], i_data.addr[RW-1:0]};
        else if (r_state == S_FETCH) rf_ra = {r_t, fw.s1};
        else if (r_state == S_OPRD && !r_rd_b) rf_ra = {r_t, r_iw.imm[RW-1:0]};
        else rf_ra = {r_t, r_iw.d};
    end
    wire [31:0] rf_rd = r_rf_qv ? r_rf_q : 32'd0;

    // memory execution
    wire [31:0] op2   = r_iw.is_imm ? immx : r_b;
    wire is_mem = (r_iw.op == OP_LOAD) || (r_iw.op == OP_STORE);
    wire mem_go = is_mem && !r_rdy[r_t] && (r_wait[r_t] == 8'd0);
    // in S_MEM: r_a = src1, r_b = src2, rf_rd = dst base
    wire [31:0] ld_addr = r_a + op2;
    wire [31:0] st_addr = rf_rd + op2;

    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.cmd == CMD_IWRITE && 32'(i_data.thread_sel) < THREADS)
            imem[{i_data.thread_sel[TW-1:0], i_data.addr[IW-1:0]}] <=
                {6'd0, i_data.src2_is_imm, i_data.src2_or_imm, i_data.src_reg,
                 i_data.dst_reg, i_data.opcode};
        r_imem_q <= imem[{t_run, r_pc[t_run]}];
    end

    logic          dm_we;
    logic [DW-1:0] dm_wa;
    logic [31:0]   dm_wd;
    always_comb begin
        dm_we = 1'b0; dm_wa = i_data.addr[DW-1:0]; dm_wd = i_data.data_value;
        if (in_acc && i_data.cmd == CMD_DWRITE) dm_we = 1'b1;
        if (r_state == S_MEM && mem_go && r_iw.op == OP_STORE) begin
            dm_we = 1'b1; dm_wa = st_addr[DW-1:0]; dm_wd = r_a;
        end
    end
    always_ff @(posedge i_clk) begin
        if (dm_we) dmem[dm_wa] <= dm_wd;
        r_dmem_q <= dmem[ld_addr[DW-1:0]];
    end

    // register write back
    logic             rf_we;
    logic [31:0]      rf_wd;
    always_comb begin
        rf_we = 1'b0;
        rf_wd = r_dmem_q;
        if (r_state == S_WB) begin
            case (r_iw.op)
                OP_ADD:  begin rf_we = 1'b1; rf_wd = r_a + r_b; end
                OP_SUB:  begin rf_we = 1'b1; rf_wd = r_a - r_b; end
                OP_ADDI: begin rf_we = 1'b1; rf_wd = r_a + immx; end
                OP_SUBI: begin rf_we = 1'b1; rf_wd = r_a - immx; end
                OP_LOAD: rf_we = r_cmd.opcode[0];  // set in S_MEM when load issued
                default: rf_we = 1'b0;
            endcase
        end
    end
    wire [RW+TW-1:0] rf_wa = {r_t, r_iw.d};

    always_ff @(posedge i_clk) begin
        if (rf_we) rf[rf_wa] <= rf_wd;
        r_rf_q <= rf[rf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_rf_qv  <= 1'b0;
        end else begin
            if (rf_we) r_rf_vld[rf_wa] <= 1'b1;
            r_rf_qv <= r_rf_vld[rf_ra];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = (i_data.cmd == CMD_RUN && !all_h) ? S_FETCH : S_OUT;
            S_FETCH: n_state = S_OPRD;
            S_OPRD:  n_state = r_rd_b ? S_MEM : S_OPRD;
            S_MEM:   n_state = S_WB;
            S_WB:    n_state = S_OUT;
            S_OUT:   if (!r_ovld || out_acc) n_state = r_ovld ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // wait countdown after a run cycle, with the memory op's new value
    logic [7:0]         w_new  [THREADS];
    logic [THREADS-1:0] rdy_new;
    logic [TW-1:0]      sw_to;
    logic               sw_real, adv, do_sw, fin_set;
    logic [7:0]         lat;
    always_comb begin
        lat = (r_iw.op == OP_LOAD) ? r_ldlat : r_stlat;
        if (lat == 8'd0) lat = 8'd1;
        adv = 1'b0; do_sw = 1'b0; fin_set = 1'b0;
        rdy_new = r_rdy;
        for (int i = 0; i < THREADS; i++) w_new[i] = r_wait[i];
        case (r_iw.op)
            OP_LOAD, OP_STORE: begin
                if (r_rdy[r_t]) begin
                    rdy_new[r_t] = 1'b0;
                    w_new[r_t] = 8'd0;
                    adv = 1'b1;
                end else begin
                    if (r_wait[r_t] == 8'd0) w_new[r_t] = lat;
                    do_sw = 1'b1;
                end
            end
            OP_HALT: begin fin_set = 1'b1; adv = 1'b1; do_sw = 1'b1; end
            default: adv = 1'b1;
        endcase
        for (int i = 0; i < THREADS; i++) begin
            if (act_mask[i]) begin
                if (w_new[i] == 8'd1) begin
                    w_new[i] = 8'd0;
                    rdy_new[i] = 1'b1;
                end else if (w_new[i] != 8'd0) begin
                    w_new[i] = w_new[i] - 8'd1;
                end
            end
        end
        sw_to = next_unf(r_t, r_fin | (fin_set ? (THREADS'(1) << r_t) : '0), n_act);
        sw_real = do_sw && (sw_to != r_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tcount <= 3'd4;
            r_ldlat  <= 8'd4;
            r_stlat  <= 8'd2;
            r_pen    <= 8'd1;
            r_cur    <= '0;
            r_cyc    <= '0;
            r_inst   <= '0;
            r_rdy    <= '0;
            r_fin    <= '0;
            r_ovld   <= 1'b0;
            r_rd_b   <= 1'b0;
            for (int i = 0; i < THREADS; i++) begin
                r_pc[i]   <= '0;
                r_wait[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THREADS: r_tcount <= i_cfg_data[2:0];
                    CFG_LDLAT:   r_ldlat  <= i_cfg_data;
                    CFG_STLAT:   r_stlat  <= i_cfg_data;
                    CFG_PENALTY: r_pen    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_acc) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: if (in_acc) begin
                    r_cmd <= i_data;
                    r_out.switched   <= 1'b0;
                    r_out.read_value <= '0;
                    if (i_data.cmd == CMD_RUN) begin
                        // with every active thread halted t_run is the clamped thread
                        r_cur <= t_run;
                        r_t   <= t_run;
                        r_out.ran_thread <= 2'(t_run);
                    end else begin
                        r_out.ran_thread <= 2'(r_cur);
                    end
                end
                S_FETCH: begin
                    r_iw   <= fw;
                    r_rd_b <= 1'b0;
                end
                S_OPRD: begin
                    if (!r_rd_b) r_a <= rf_rd; else r_b <= rf_rd;
                    r_rd_b <= 1'b1;
                end
                S_MEM: begin
                    // carry "load issued" in a spare command bit
                    r_cmd.opcode[0] <= mem_go && (r_iw.op == OP_LOAD);
                    r_rd_b <= 1'b0;
                end
                S_WB: begin
                    for (int i = 0; i < THREADS; i++) r_wait[i] <= w_new[i];
                    r_rdy <= rdy_new;
                    if (fin_set) r_fin[r_t] <= 1'b1;
                    if (adv) begin
                        r_pc[r_t] <= r_pc[r_t] + IW'(1);
                        r_inst    <= r_inst + 32'd1;
                    end
                    r_cyc <= r_cyc + 32'd1 + (sw_real ? 32'(r_pen) : 32'd0);
                    if (sw_real) r_cur <= sw_to;
                    r_out.switched <= sw_real;
                end
                S_OUT: if (!r_ovld) begin
                    r_ovld <= 1'b1;
                    r_out.all_done    <= all_h;
                    r_out.cycle_count <= r_cyc;
                    r_out.inst_count  <= r_inst;
                    if (r_cmd.cmd == CMD_RREAD && 32'(r_cmd.thread_sel) < THREADS)
                        r_out.read_value <= rf_rd;
                end
                default: ;
            endcase
        end
    end

    // the command register only changes on an accepted transaction or in S_MEM
    // result register is ever pending only in S_OUT
    a_ovld_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_state == S_OUT || r_state == S_IDLE))
        else $error("result pending outside output phase");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("second command accepted while busy");
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && sw_real) |=> (r_cur != $past(r_t)))
        else $error("switch kept same thread");

endmodule
